@@ rtl/core/rlce_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// rlce_pkg
// Shared types and constants of the LED chain encoder.
// ----------------------------------------------------------------------------
package rlce_pkg;

   localparam int COLOR_W        = 24;
   localparam int CODE_W         = 8;
   localparam int RUN_W          = 10;
   localparam int LED_COUNT_W    = 11;
   localparam int CSR_INDEX_W    = 2;
   localparam int CSR_DATA_W     = 11;
   localparam int MAX_LEDS_DEF   = 1024;
   localparam int QUEUE_DEPTH    = 2;

   localparam int SLOT_W         = 5;
   localparam logic [SLOT_W-1:0] SLOT_RUN   = SLOT_W'(0);
   localparam logic [SLOT_W-1:0] SLOT_FIRST = SLOT_W'(1);
   localparam logic [SLOT_W-1:0] SLOT_GAP   = SLOT_W'(COLOR_W + 1);

   localparam logic [CODE_W-1:0]      ONE_CODE_RST    = CODE_W'(71);
   localparam logic [CODE_W-1:0]      ZERO_CODE_RST   = CODE_W'(32);
   localparam logic [RUN_W-1:0]       RESET_SLOTS_RST = RUN_W'(240);
   localparam logic [LED_COUNT_W-1:0] LED_COUNT_RST   = LED_COUNT_W'(1024);

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_ONE_CODE    = 2'd0,
      CSR_ZERO_CODE   = 2'd1,
      CSR_RESET_SLOTS = 2'd2,
      CSR_LED_COUNT   = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic [CODE_W-1:0]      one_code;
      logic [CODE_W-1:0]      zero_code;
      logic [RUN_W-1:0]       reset_slots;
      logic [LED_COUNT_W-1:0] led_count;
   } cfg_type;

   typedef struct packed {
      logic [COLOR_W-1:0] grb;
      logic               first;
   } pix_type;

   typedef struct packed {
      logic valid;
      logic full;
   } queue_status_type;

endpackage
`default_nettype wire

@@ rtl/core/rgb_led_chain_pwm_encoder_unit.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// rgb_led_chain_pwm_encoder_unit
// Turns RGB pixels into a stream of PWM compare codes for a serial LED chain.
// ----------------------------------------------------------------------------
// The req channel takes one 24-bit RGB color per item. The rsp channel gives
// one PWM slot or run per item: a reset run before the first pixel of each
// frame, 24 bit slots in GRB order with the most significant bit first, and
// a gap slot that carries end_of_pixel.
// The output register sends one result per cycle while the receiver does not
// stall, so a pixel gives 25 results, or 26 when it opens a frame. Each pixel
// goes through the queue, the back's slot state and the output register.
// A two-entry queue between the front and the back lets the next pixels be
// accepted while the current one is still being sent; req_stall is high only
// while that queue is full.
// When the receiver stalls, the current result holds and the back pauses.
// Reset empties the queue and the output register, restarts the frame at the
// first pixel and loads the default register values. The csr port may be
// written only while the block is idle.
// ----------------------------------------------------------------------------
module rgb_led_chain_pwm_encoder_unit #(
   parameter int MAX_LEDS = rlce_pkg::MAX_LEDS_DEF
) (
   input  wire                               clock,
   input  wire                               reset,
   input  wire                               req_valid,
   output logic                              req_stall,
   input  wire  [rlce_pkg::COLOR_W-1:0]      req_color,
   output logic                              rsp_valid,
   input  wire                               rsp_stall,
   output logic [rlce_pkg::CODE_W-1:0]       rsp_duty_code,
   output logic [rlce_pkg::RUN_W-1:0]        rsp_repeat_res,
   output logic                              rsp_end_of_pixel,
   input  wire                               csr_wr_en,
   input  wire  [rlce_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  wire  [rlce_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import rlce_pkg::*;

   cfg_type           cfg_ff, cfg_in;
   queue_status_type  q_status;
   pix_type           push_item;
   pix_type           pop_item;
   logic              push;
   logic              pop;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         case (csr_index_type'(csr_index))
            CSR_ONE_CODE:    cfg_in.one_code    = csr_wdata[CODE_W-1:0];
            CSR_ZERO_CODE:   cfg_in.zero_code   = csr_wdata[CODE_W-1:0];
            CSR_RESET_SLOTS: cfg_in.reset_slots = csr_wdata[RUN_W-1:0];
            CSR_LED_COUNT:   cfg_in.led_count   = csr_wdata[LED_COUNT_W-1:0];
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.one_code    <= ONE_CODE_RST;
         cfg_ff.zero_code   <= ZERO_CODE_RST;
         cfg_ff.reset_slots <= RESET_SLOTS_RST;
         cfg_ff.led_count   <= LED_COUNT_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   rlce_front #(
      .MAX_LEDS (MAX_LEDS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_color (req_color),
      .led_count (cfg_ff.led_count),
      .q_status  (q_status),
      .push      (push),
      .push_item (push_item)
   );

   rlce_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop       (pop),
      .pop_item  (pop_item),
      .status    (q_status)
   );

   rlce_back u_back (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg_ff),
      .q_status         (q_status),
      .q_item           (pop_item),
      .pop              (pop),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_duty_code    (rsp_duty_code),
      .rsp_repeat_res   (rsp_repeat_res),
      .rsp_end_of_pixel (rsp_end_of_pixel)
   );

   a_pop_needs_item: assert property (@(posedge clock) disable iff (reset)
      pop |-> q_status.valid)
      else $error("queue popped while empty");

   a_gap_slot_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_end_of_pixel |-> rsp_duty_code == '0 && rsp_repeat_res == RUN_W'(1))
      else $error("gap slot with wrong duty code or repeat count");

   a_repeat_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_repeat_res != '0)
      else $error("result with empty repeat count");

   a_idle_after_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");

endmodule
`default_nettype wire

@@ rtl/core/rlce_front.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// rlce_front
// Accepts pixels, reorders them to GRB and marks the pixel that opens a frame.
// ----------------------------------------------------------------------------
module rlce_front #(
   parameter int MAX_LEDS = rlce_pkg::MAX_LEDS_DEF
) (
   input  wire                               clock,
   input  wire                               reset,
   input  wire                               req_valid,
   output logic                              req_stall,
   input  wire  [rlce_pkg::COLOR_W-1:0]      req_color,
   input  wire  [rlce_pkg::LED_COUNT_W-1:0]  led_count,
   input  wire  rlce_pkg::queue_status_type  q_status,
   output logic                              push,
   output rlce_pkg::pix_type                 push_item
);
   import rlce_pkg::*;

   localparam int IDX_W = (MAX_LEDS > 1) ? $clog2(MAX_LEDS) : 1;
   localparam int CNT_W = $clog2(MAX_LEDS + 1);
   localparam int CMP_W = (CNT_W > LED_COUNT_W) ? CNT_W : LED_COUNT_W;

   logic [IDX_W-1:0] pixel_index_ff, pixel_index_in;
   logic [CMP_W-1:0] led_ext, frame_len, next_idx;

   assign req_stall = q_status.full;
   assign push      = req_valid && !req_stall;

   assign push_item.grb   = {req_color[15:8], req_color[23:16], req_color[7:0]};
   assign push_item.first = (pixel_index_ff == '0);

   always_comb begin
      led_ext = CMP_W'(led_count);
      if (led_ext == '0) begin
         frame_len = CMP_W'(1);
      end else if (led_ext > CMP_W'(MAX_LEDS)) begin
         frame_len = CMP_W'(MAX_LEDS);
      end else begin
         frame_len = led_ext;
      end
      next_idx = CMP_W'(pixel_index_ff) + CMP_W'(1);
      pixel_index_in = pixel_index_ff;
      if (push) begin
         if (next_idx >= frame_len) begin
            pixel_index_in = '0;
         end else begin
            pixel_index_in = next_idx[IDX_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pixel_index_ff <= '0;
      end else begin
         pixel_index_ff <= pixel_index_in;
      end
   end

endmodule
`default_nettype wire

@@ rtl/core/rlce_queue.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// rlce_queue
// Short queue of classified pixels between the front and the back.
// ----------------------------------------------------------------------------
module rlce_queue (
   input  wire                               clock,
   input  wire                               reset,
   input  wire                               push,
   input  wire  rlce_pkg::pix_type           push_item,
   input  wire                               pop,
   output rlce_pkg::pix_type                 pop_item,
   output rlce_pkg::queue_status_type        status
);
   import rlce_pkg::*;

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   pix_type            entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;

   function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
      logic [PTR_W-1:0] r;
      if (p == PTR_W'(QUEUE_DEPTH - 1)) begin
         r = '0;
      end else begin
         r = p + PTR_W'(1);
      end
      return r;
   endfunction

   assign status.valid = (count_ff != '0);
   assign status.full  = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign pop_item     = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ptr_next(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop ? ptr_next(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule
`default_nettype wire

@@ rtl/core/rlce_back.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// rlce_back
// Serializes a pixel: reset run if first in frame, 24 bit slots, gap slot.
// ----------------------------------------------------------------------------
module rlce_back (
   input  wire                               clock,
   input  wire                               reset,
   input  wire  rlce_pkg::cfg_type           cfg,
   input  wire  rlce_pkg::queue_status_type  q_status,
   input  wire  rlce_pkg::pix_type           q_item,
   output logic                              pop,
   output logic                              rsp_valid,
   input  wire                               rsp_stall,
   output logic [rlce_pkg::CODE_W-1:0]       rsp_duty_code,
   output logic [rlce_pkg::RUN_W-1:0]        rsp_repeat_res,
   output logic                              rsp_end_of_pixel
);
   import rlce_pkg::*;

   logic                  active_ff, active_in;
   logic [SLOT_W-1:0]     slot_ff, slot_in;
   logic [COLOR_W-1:0]    shift_ff, shift_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [CODE_W-1:0]     duty_ff, duty_in;
   logic [RUN_W-1:0]      rep_ff, rep_in;
   logic                  eop_ff, eop_in;
   logic                  out_free;
   logic                  last_slot;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign last_slot = active_ff && (slot_ff == SLOT_GAP);
   assign pop       = out_free && (!active_ff || last_slot) && q_status.valid;

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_duty_code    = duty_ff;
   assign rsp_repeat_res   = rep_ff;
   assign rsp_end_of_pixel = eop_ff;

   always_comb begin
      active_in    = active_ff;
      slot_in      = slot_ff;
      shift_in     = shift_ff;
      rsp_valid_in = rsp_valid_ff;
      duty_in      = duty_ff;
      rep_in       = rep_ff;
      eop_in       = eop_ff;
      if (out_free) begin
         rsp_valid_in = active_ff;
         if (active_ff) begin
            if (slot_ff == SLOT_RUN) begin
               duty_in = '0;
               rep_in  = (cfg.reset_slots == '0) ? RUN_W'(1) : cfg.reset_slots;
               eop_in  = 1'b0;
            end else if (slot_ff == SLOT_GAP) begin
               duty_in = '0;
               rep_in  = RUN_W'(1);
               eop_in  = 1'b1;
            end else begin
               duty_in  = shift_ff[COLOR_W-1] ? cfg.one_code : cfg.zero_code;
               rep_in   = RUN_W'(1);
               eop_in   = 1'b0;
               shift_in = {shift_ff[COLOR_W-2:0], 1'b0};
            end
            slot_in = slot_ff + SLOT_W'(1);
            if (last_slot) begin
               active_in = 1'b0;
            end
         end
         if (pop) begin
            active_in = 1'b1;
            slot_in   = q_item.first ? SLOT_RUN : SLOT_FIRST;
            shift_in  = q_item.grb;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         active_ff    <= active_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      slot_ff  <= slot_in;
      shift_ff <= shift_in;
      duty_ff  <= duty_in;
      rep_ff   <= rep_in;
      eop_ff   <= eop_in;
   end

endmodule
`default_nettype wire

@@ dv/led_code_checker.sv @@
// ----------------------------------------------------------------------------
// led_code_checker
// Predicts and checks the PWM slot stream of the LED chain encoder.
// ----------------------------------------------------------------------------
// Watches the req, rsp and csr ports of the encoder. Keeps its own copy of the
// registers and of the position within the frame, turns every accepted pixel
// into the slots it must produce, and compares each accepted rsp item field by
// field with the oldest slot still waiting. Mismatches are counted and handed
// to the testbench top together with the number of slots still waiting.
// ----------------------------------------------------------------------------
module led_code_checker #(
   parameter int MAX_LEDS = rlce_pkg::MAX_LEDS_DEF
) (
   input  wire                               clock,
   input  wire                               reset,
   input  wire                               req_valid,
   input  wire                               req_stall,
   input  wire  [rlce_pkg::COLOR_W-1:0]      req_color,
   input  wire                               rsp_valid,
   input  wire                               rsp_stall,
   input  wire  [rlce_pkg::CODE_W-1:0]       rsp_duty_code,
   input  wire  [rlce_pkg::RUN_W-1:0]        rsp_repeat_res,
   input  wire                               rsp_end_of_pixel,
   input  wire                               csr_wr_en,
   input  wire  [rlce_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  wire  [rlce_pkg::CSR_DATA_W-1:0]   csr_wdata,
   output int                                mismatches,
   output int                                open_slots
);
   import rlce_pkg::*;

   typedef struct packed {
      logic [CODE_W-1:0] duty;
      logic [RUN_W-1:0]  run;
      logic              eop;
   } slot_type;

   slot_type expected_slots[$];
   cfg_type  cfg;
   int       frame_pos;

   initial begin
      mismatches = 0;
      open_slots = 0;
   end

   function automatic int frame_len();
      int n;
      n = int'(cfg.led_count);
      if (n == 0) begin
         n = 1;
      end
      if (n > MAX_LEDS) begin
         n = MAX_LEDS;
      end
      return n;
   endfunction

   task automatic encode_pixel(input logic [COLOR_W-1:0] color);
      logic [COLOR_W-1:0] grb;
      slot_type           s;
      int                 i;
      grb = {color[15:8], color[23:16], color[7:0]};
      if (frame_pos == 0) begin
         s.duty = '0;
         s.run  = (cfg.reset_slots == '0) ? RUN_W'(1) : cfg.reset_slots;
         s.eop  = 1'b0;
         expected_slots.push_back(s);
      end
      for (i = COLOR_W - 1; i >= 0; i--) begin
         s.duty = grb[i] ? cfg.one_code : cfg.zero_code;
         s.run  = RUN_W'(1);
         s.eop  = 1'b0;
         expected_slots.push_back(s);
      end
      s.duty = '0;
      s.run  = RUN_W'(1);
      s.eop  = 1'b1;
      expected_slots.push_back(s);
      frame_pos++;
      if (frame_pos >= frame_len()) begin
         frame_pos = 0;
      end
   endtask

   task automatic report_field(input string field, input int exp_val, input int act_val);
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, exp_val,
               act_val);
      mismatches++;
   endtask

   always @(posedge clock) begin
      slot_type exp_slot;
      if (reset) begin
         cfg = '{ONE_CODE_RST, ZERO_CODE_RST, RESET_SLOTS_RST, LED_COUNT_RST};
         frame_pos = 0;
         expected_slots.delete();
      end else begin
         if (csr_wr_en) begin
            case (csr_index_type'(csr_index))
               CSR_ONE_CODE: begin
                  cfg.one_code = csr_wdata[CODE_W-1:0];
               end
               CSR_ZERO_CODE: begin
                  cfg.zero_code = csr_wdata[CODE_W-1:0];
               end
               CSR_RESET_SLOTS: begin
                  cfg.reset_slots = csr_wdata[RUN_W-1:0];
               end
               CSR_LED_COUNT: begin
                  cfg.led_count = csr_wdata[LED_COUNT_W-1:0];
               end
               default: begin
               end
            endcase
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_slots.size() == 0) begin
               $display("%0t: unexpected item, expected none, actual duty %0d run %0d eop %0d",
                        $time, rsp_duty_code, rsp_repeat_res, rsp_end_of_pixel);
               mismatches++;
            end else begin
               exp_slot = expected_slots.pop_front();
               if (rsp_duty_code !== exp_slot.duty) begin
                  report_field("duty_code", exp_slot.duty, rsp_duty_code);
               end
               if (rsp_repeat_res !== exp_slot.run) begin
                  report_field("repeat_res", exp_slot.run, rsp_repeat_res);
               end
               if (rsp_end_of_pixel !== exp_slot.eop) begin
                  report_field("end_of_pixel", exp_slot.eop, rsp_end_of_pixel);
               end
            end
         end
         if (req_valid && !req_stall) begin
            encode_pixel(req_color);
         end
      end
      open_slots = expected_slots.size();
   end

endmodule

@@ dv/tb_rgb_led_chain_pwm_encoder_unit.sv @@
// ----------------------------------------------------------------------------
// tb_rgb_led_chain_pwm_encoder_unit
// Testbench of the LED chain PWM encoder.
// ----------------------------------------------------------------------------
// Drives pixels into the encoder under a series of register settings, first a
// short directed set of colors and settings, then random phases with random
// colors and registers. Both channels idle in random bursts, and once the
// receiver holds off long enough for the encoder to fill up and stall its
// input. A checker beside the encoder predicts and compares every slot.
// ----------------------------------------------------------------------------
module tb_rgb_led_chain_pwm_encoder_unit;
   import rlce_pkg::*;

   localparam int CYCLE_LIMIT  = 400000;
   localparam int PIXEL_TARGET = 460;
   localparam int CALM_FROM    = 400;
   localparam int LONG_HOLD    = 300;

   logic                   clock = 1'b0;
   logic                   reset;
   logic                   req_valid;
   logic                   req_stall;
   logic [COLOR_W-1:0]     req_color;
   logic                   rsp_valid;
   logic                   rsp_stall;
   logic [CODE_W-1:0]      rsp_duty_code;
   logic [RUN_W-1:0]       rsp_repeat_res;
   logic                   rsp_end_of_pixel;
   logic                   csr_wr_en;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;

   int mismatches;
   int open_slots;
   int pixels_sent = 0;
   int cycle_count = 0;
   bit idle_on = 1'b0;
   bit long_hold_req = 1'b0;

   always #4 clock = ~clock;

   rgb_led_chain_pwm_encoder_unit dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_color        (req_color),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_duty_code    (rsp_duty_code),
      .rsp_repeat_res   (rsp_repeat_res),
      .rsp_end_of_pixel (rsp_end_of_pixel),
      .csr_wr_en        (csr_wr_en),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   led_code_checker checker_i (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_color        (req_color),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_duty_code    (rsp_duty_code),
      .rsp_repeat_res   (rsp_repeat_res),
      .rsp_end_of_pixel (rsp_end_of_pixel),
      .csr_wr_en        (csr_wr_en),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .mismatches       (mismatches),
      .open_slots       (open_slots)
   );

   task automatic send_pixel(input logic [COLOR_W-1:0] color);
      int gap;
      if (idle_on && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 10);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_color <= color;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      pixels_sent++;
   endtask

   task automatic drain_block();
      req_valid <= 1'b0;
      @(posedge clock);
      while (open_slots != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_regs(input logic [CSR_DATA_W-1:0] one_val,
                             input logic [CSR_DATA_W-1:0] zero_val,
                             input logic [CSR_DATA_W-1:0] slots_val,
                             input logic [CSR_DATA_W-1:0] count_val);
      csr_wr_en <= 1'b1;
      csr_index <= CSR_ONE_CODE;
      csr_wdata <= one_val;
      @(posedge clock);
      csr_index <= CSR_ZERO_CODE;
      csr_wdata <= zero_val;
      @(posedge clock);
      csr_index <= CSR_RESET_SLOTS;
      csr_wdata <= slots_val;
      @(posedge clock);
      csr_index <= CSR_LED_COUNT;
      csr_wdata <= count_val;
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   function automatic logic [COLOR_W-1:0] pick_color();
      logic [COLOR_W-1:0] corners[6];
      corners = '{24'h000000, 24'hFFFFFF, 24'hFF0000, 24'h00FF00, 24'h0000FF, 24'h800001};
      if ($urandom_range(0, 7) == 0) begin
         return corners[$urandom_range(0, 5)];
      end
      return COLOR_W'($urandom());
   endfunction

   function automatic logic [CSR_DATA_W-1:0] pick_led_count();
      case ($urandom_range(0, 9))
         0: return '0;
         1: return CSR_DATA_W'(2047);
         2: return CSR_DATA_W'($urandom_range(1024, 2047));
         3: return CSR_DATA_W'($urandom_range(9, 60));
         default: return CSR_DATA_W'($urandom_range(1, 8));
      endcase
   endfunction

   initial begin
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (long_hold_req) begin
            long_hold_req = 1'b0;
            rsp_stall <= 1'b1;
            repeat (LONG_HOLD) @(posedge clock);
            rsp_stall <= 1'b0;
         end else if (idle_on && $urandom_range(0, 4) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 10)) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("tb_rgb_led_chain_pwm_encoder_unit failed");
      $finish;
   end

   initial begin
      int phase;
      int n;
      int k;
      reset     <= 1'b1;
      req_valid <= 1'b0;
      req_color <= '0;
      csr_wr_en <= 1'b0;
      csr_index <= CSR_ONE_CODE;
      csr_wdata <= '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Default registers, frame much longer than the pixels sent.
      send_pixel(24'h000000);
      send_pixel(24'hFFFFFF);
      send_pixel(24'hFF0000);
      send_pixel(24'h00FF00);
      send_pixel(24'h0000FF);
      send_pixel(24'hA5C381);
      drain_block();

      // Extreme codes with high data bits set, shortest reset run, one-pixel frame.
      write_regs(11'h7FF, 11'h000, 11'h001, 11'h001);
      send_pixel(24'h800001);
      send_pixel(24'h7FFFFE);
      send_pixel(24'h123456);
      drain_block();

      // A zero reset run and a zero frame length both act as one.
      write_regs(11'h000, 11'h0FF, 11'h000, 11'h000);
      send_pixel(24'h555555);
      send_pixel(24'hAAAAAA);
      drain_block();

      // Longest reset run and a frame length above the maximum.
      write_regs(11'h055, 11'h0AA, 11'h3FF, 11'h7FF);
      send_pixel(24'hF0F0F0);
      send_pixel(24'h0F0F0F);
      drain_block();

      // Frame of five, then the length is lowered in the middle of the frame.
      write_regs(11'h047, 11'h020, 11'h405, 11'h005);
      send_pixel(24'h010203);
      send_pixel(24'h102030);
      send_pixel(24'hC0FFEE);
      send_pixel(24'h00FF00);
      drain_block();
      write_regs(11'h047, 11'h020, 11'h405, 11'h002);
      send_pixel(24'hFEDCBA);
      send_pixel(24'h3C3C3C);
      drain_block();

      phase = 0;
      while (pixels_sent < PIXEL_TARGET) begin
         idle_on = (pixels_sent < CALM_FROM) && ($urandom_range(0, 3) != 0);
         write_regs(CSR_DATA_W'($urandom()), CSR_DATA_W'($urandom()),
                    ($urandom_range(0, 7) == 0) ? CSR_DATA_W'(0) : CSR_DATA_W'($urandom()),
                    pick_led_count());
         if (phase == 3) begin
            idle_on = 1'b1;
            long_hold_req = 1'b1;
         end
         n = $urandom_range(10, 40);
         for (k = 0; k < n && pixels_sent < PIXEL_TARGET; k++) begin
            send_pixel(pick_color());
         end
         drain_block();
         phase++;
      end

      idle_on = 1'b0;
      req_valid <= 1'b0;
      @(posedge clock);
      while (open_slots != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (mismatches == 0 && open_slots == 0) begin
         $display("tb_rgb_led_chain_pwm_encoder_unit passed");
      end else begin
         $display("tb_rgb_led_chain_pwm_encoder_unit failed");
      end
      $finish;
   end

endmodule

@@ files.f @@
rtl/core/rlce_pkg.sv
rtl/core/rlce_front.sv
rtl/core/rlce_queue.sv
rtl/core/rlce_back.sv
rtl/core/rgb_led_chain_pwm_encoder_unit.sv
dv/led_code_checker.sv
dv/tb_rgb_led_chain_pwm_encoder_unit.sv
